FILE: design/pdc_pkg.sv
package pdc_pkg;

  localparam int VALUE_W = 31;
  localparam int COUNT_W = 6;
  localparam int DEFAULT_MAX_ELEMENTS = 64;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_LOAD,
    CELL_SWEEP,
    CELL_DRAIN
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [VALUE_W-1:0]   elem;
    logic [VALUE_W-1:0]   key;
  } cell_ctrl_t;

endpackage

FILE: design/pdc_cell.sv
module pdc_cell
  import pdc_pkg::*;
(
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic               occ_i,
  input  logic               left_cond_i,
  input  logic [VALUE_W-1:0] left_value_i,
  input  logic [VALUE_W-1:0] right_travel_i,
  input  logic               right_tvalid_i,
  input  logic               right_matched_i,
  output logic               cond_o,
  output logic [VALUE_W-1:0] value_o,
  output logic [VALUE_W-1:0] travel_o,
  output logic               tvalid_o,
  output logic               matched_o
);

  logic [VALUE_W-1:0] value_q;
  logic [VALUE_W-1:0] travel_q;
  logic               tvalid_q;
  logic               matched_q;
  logic [VALUE_W:0]   target;
  logic               hit;

  assign cond_o    = !occ_i || (ctrl_i.elem < value_q);
  assign target    = {1'b0, value_q} + {1'b0, ctrl_i.key};
  assign hit       = occ_i && right_tvalid_i && ({1'b0, right_travel_i} == target);
  assign value_o   = value_q;
  assign travel_o  = travel_q;
  assign tvalid_o  = tvalid_q;
  assign matched_o = matched_q;

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (cond_o) begin
          value_q <= left_cond_i ? left_value_i : ctrl_i.elem;
        end
      end
      CELL_LOAD: begin
        travel_q  <= value_q;
        tvalid_q  <= occ_i;
        matched_q <= 1'b0;
      end
      CELL_SWEEP: begin
        travel_q <= right_travel_i;
        tvalid_q <= right_tvalid_i;
        if (hit) begin
          matched_q <= 1'b1;
        end
      end
      CELL_DRAIN: begin
        matched_q <= right_matched_i;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/pair_difference_count_unit.sv
// Elements are taken one per cycle, while the block is in its fill state, into a sorting row of cells.
// After the final element the stored elements are loaded, then swept and drained through the row
// before the result is offered, and no new element is taken until the result is transferred.
// Reset clears the element count, the overflow flag, the difference key and the control state.
module pair_difference_count_unit
  import pdc_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [VALUE_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [VALUE_W-1:0] element_value_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] pair_count_o,
  output logic               overflow_o
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ELEMENTS);

  typedef enum logic [2:0] {
    S_FILL,
    S_PREP,
    S_SWEEP,
    S_DRAIN,
    S_OUT
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   step_q;
  logic [CNT_W-1:0]   last_step;
  logic               ovf_q;
  logic [VALUE_W-1:0] key_q;
  logic [COUNT_W-1:0] pc_q;
  logic               in_xfer;
  logic               has_room;
  cell_ctrl_t         ctrl;

  logic [VALUE_W-1:0] value_w   [MAX_ELEMENTS];
  logic [VALUE_W-1:0] travel_w  [MAX_ELEMENTS];
  logic               cond_w    [MAX_ELEMENTS];
  logic               tvalid_w  [MAX_ELEMENTS];
  logic               matched_w [MAX_ELEMENTS];

  assign in_stall_o   = (state_q != S_FILL);
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign has_room     = (cnt_q != CNT_FULL);
  assign last_step    = CNT_W'(cnt_q - 1'b1);
  assign out_valid_o  = (state_q == S_OUT);
  assign pair_count_o = pc_q;
  assign overflow_o   = ovf_q;

  always_comb begin
    ctrl.elem = element_value_i;
    ctrl.key  = key_q;
    case (state_q)
      S_FILL:  ctrl.op = (in_xfer && has_room) ? CELL_INSERT : CELL_HOLD;
      S_PREP:  ctrl.op = CELL_LOAD;
      S_SWEEP: ctrl.op = CELL_SWEEP;
      S_DRAIN: ctrl.op = CELL_DRAIN;
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    logic               occ;
    logic               l_cond;
    logic [VALUE_W-1:0] l_value;
    logic [VALUE_W-1:0] r_travel;
    logic               r_tvalid;
    logic               r_matched;

    assign occ = (cnt_q > CNT_W'(k));

    if (k == 0) begin : g_head
      assign l_cond  = 1'b0;
      assign l_value = '0;
    end else begin : g_body
      assign l_cond  = cond_w[k-1];
      assign l_value = value_w[k-1];
    end

    if (k == MAX_ELEMENTS - 1) begin : g_tail
      assign r_travel  = '0;
      assign r_tvalid  = 1'b0;
      assign r_matched = 1'b0;
    end else begin : g_inner
      assign r_travel  = travel_w[k+1];
      assign r_tvalid  = tvalid_w[k+1];
      assign r_matched = matched_w[k+1];
    end

    pdc_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .occ_i          (occ),
      .left_cond_i    (l_cond),
      .left_value_i   (l_value),
      .right_travel_i (r_travel),
      .right_tvalid_i (r_tvalid),
      .right_matched_i(r_matched),
      .cond_o         (cond_w[k]),
      .value_o        (value_w[k]),
      .travel_o       (travel_w[k]),
      .tvalid_o       (tvalid_w[k]),
      .matched_o      (matched_w[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL;
      cnt_q   <= '0;
      step_q  <= '0;
      ovf_q   <= 1'b0;
      key_q   <= '0;
      pc_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        key_q <= cfg_wdata_i;
      end
      case (state_q)
        S_FILL: begin
          if (in_xfer) begin
            if (has_room) begin
              cnt_q <= CNT_W'(cnt_q + 1'b1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_element_i) begin
              state_q <= S_PREP;
            end
          end
        end
        S_PREP: begin
          pc_q    <= '0;
          step_q  <= '0;
          state_q <= S_SWEEP;
        end
        S_SWEEP: begin
          if (step_q == last_step) begin
            step_q  <= '0;
            state_q <= S_DRAIN;
          end else begin
            step_q <= CNT_W'(step_q + 1'b1);
          end
        end
        S_DRAIN: begin
          if (matched_w[0] && (pc_q != COUNT_MAX)) begin
            pc_q <= COUNT_W'(pc_q + 1'b1);
          end
          if (step_q == last_step) begin
            step_q  <= '0;
            state_q <= S_OUT;
          end else begin
            step_q <= CNT_W'(step_q + 1'b1);
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= S_FILL;
          end
        end
        default: begin
          state_q <= S_FILL;
        end
      endcase
    end
  end

endmodule
